@@ sv/lbd_pkg.sv @@
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants for the LCD bitmap draw engine.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int unsigned ScreenW = 120;
  localparam int unsigned ScreenH = 32;
  localparam int unsigned TextLines = ScreenH / 8;
  localparam int unsigned RowAw = $clog2(ScreenH);
  localparam int unsigned ColAw = $clog2(ScreenW);

  typedef enum logic [3:0] {
    REQ_SET    = 4'd0,
    REQ_CLR    = 4'd1,
    REQ_INV    = 4'd2,
    REQ_TEST   = 4'd3,
    REQ_LINE   = 4'd4,
    REQ_CIRCLE = 4'd5,
    REQ_CLRTXT = 4'd6,
    REQ_CLRALL = 4'd7,
    REQ_SCROLL = 4'd8
  } req_e;

  localparam logic CfgScrollTop = 1'b0;
  localparam logic CfgScrollEnd = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_LINE,
    ST_CIRC,
    ST_ROWCLR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture command fields
    logic pix_rd;     // issue read of pixel row
    logic pix_wr;     // write modified pixel row
    logic line_step;  // line stepper advances
    logic line_init;
    logic circ_step;
    logic circ_init;
    logic row_clr;    // write zero row at row counter
    logic row_init;
    logic scr_init;   // set up scroll copy range
    logic scr_rd;
    logic scr_wr;
    logic done;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic line_last;
    logic circ_last;
    logic row_last;
    logic scr_ok;
    logic scr_copy_last;
  } sts_t;

endpackage

@@ sv/lbd_ram.sv @@
// ----------------------------------------------------------------------------
// lbd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ sv/lbd_datapath.sv @@
// ----------------------------------------------------------------------------
// lbd_datapath
// Bitmap store with per-row valid bits, line and circle steppers, row sweeps.
// ----------------------------------------------------------------------------
module lbd_datapath import lbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  output sts_t       sts_o,
  input  logic [3:0] req_type_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [7:0] radius_i,
  input  logic [7:0] scroll_top_i,
  input  logic [8:0] scroll_end_i,
  output logic       pixel_value_o
);

  // command fields
  req_e        kind_q;
  logic [7:0]  xs_q, ys_q, xe_q, ye_q;

  // row valid bits (unwritten rows read as zero)
  logic [ScreenH-1:0] vld_q;

  // plot point: the steppers produce one point at a time, and each
  // drains through a read-modify-write before the next is taken
  logic signed [10:0] px_q, py_q;
  logic [1:0]         pix_op_q;  // 0 set 1 clear 2 invert

  // line stepper
  logic signed [10:0] lx_q, ly_q, lerr_q, ldx_q, ldy_q;
  logic               lsx_q, lsy_q, lxmaj_q;
  logic [1:0]         lphase_q;  // 0 start point 1 stepping 2 end point

  // circle stepper
  logic signed [10:0] cu_q, cv_q, cd_q;
  logic [2:0]         cpt_q;     // which of four points
  logic               cstep_q;   // 0 axis points, 1 quadrant
  logic               czero_q;

  // row sweep
  logic [8:0] row_q, row_end_q;
  logic [RowAw-1:0] scr_src_q;

  logic [RowAw-1:0]   addr;
  logic               we;
  logic [ScreenW-1:0] wdata, rdata;
  logic               pix_on;

  assign pix_on = (px_q >= 0) && (py_q >= 0) &&
                  (px_q < 11'(ScreenW)) && (py_q < 11'(ScreenH));

  // row read data valid for the registered address
  logic [RowAw-1:0] raddr_q;
  logic [ScreenW-1:0] rrow_q;
  assign rrow_q = vld_q[raddr_q] ? rdata : '0;

  always_comb begin
    addr  = py_q[RowAw-1:0];
    we    = 1'b0;
    wdata = rrow_q;
    if (ctl_i.pix_wr) begin
      addr = raddr_q;
      we   = pix_on && (kind_q != REQ_TEST);
      unique case (pix_op_q)
        2'd1:    wdata[px_q[ColAw-1:0]] = 1'b0;
        2'd2:    wdata[px_q[ColAw-1:0]] = ~rrow_q[px_q[ColAw-1:0]];
        default: wdata[px_q[ColAw-1:0]] = 1'b1;
      endcase
    end else if (ctl_i.row_clr) begin
      addr  = row_q[RowAw-1:0];
      we    = (row_q < 9'(ScreenH));
      wdata = '0;
    end else if (ctl_i.scr_rd) begin
      addr = scr_src_q;
    end else if (ctl_i.scr_wr) begin
      addr  = row_q[RowAw-1:0];
      we    = 1'b1;
      wdata = rrow_q;
    end
  end

  lbd_ram #(.Width(ScreenW), .Depth(ScreenH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // current plot point from steppers
  logic signed [10:0] nx, ny;
  always_comb begin
    nx = lx_q;
    ny = ly_q;
    if (kind_q == REQ_CIRCLE) begin
      nx = 11'($signed({3'b0, xs_q}));
      ny = 11'($signed({3'b0, ys_q}));
      if (czero_q) begin
        nx = nx;
      end else if (!cstep_q) begin
        unique case (cpt_q[1:0])
          2'd0: ny = ny + cv_q;
          2'd1: ny = ny - cv_q;
          2'd2: nx = nx + cv_q;
          default: nx = nx - cv_q;
        endcase
      end else begin
        unique case (cpt_q[1:0])
          2'd0: begin nx = nx + cu_q; ny = ny + cv_q; end
          2'd1: begin nx = nx - cu_q; ny = ny + cv_q; end
          2'd2: begin nx = nx - cu_q; ny = ny - cv_q; end
          default: begin nx = nx + cu_q; ny = ny - cv_q; end
        endcase
      end
    end else if (lphase_q == 2'd0) begin
      nx = 11'($signed({3'b0, xs_q}));
      ny = 11'($signed({3'b0, ys_q}));
    end else if (lphase_q == 2'd2) begin
      nx = 11'($signed({3'b0, xe_q}));
      ny = 11'($signed({3'b0, ye_q}));
    end
  end

  // line next step
  logic signed [10:0] lx_n, ly_n, lerr_n;
  logic               line_at_end;
  always_comb begin
    lx_n   = lx_q;
    ly_n   = ly_q;
    lerr_n = lerr_q;
    if (lxmaj_q) begin
      if (lerr_q >= 0) begin
        ly_n   = lsy_q ? ly_q - 11'sd1 : ly_q + 11'sd1;
        lerr_n = lerr_q - ldx_q;
      end
      lx_n   = lsx_q ? lx_q - 11'sd1 : lx_q + 11'sd1;
      lerr_n = lerr_n + ldy_q;
    end else begin
      if (lerr_q >= 0) begin
        lx_n   = lsx_q ? lx_q - 11'sd1 : lx_q + 11'sd1;
        lerr_n = lerr_q - ldy_q;
      end
      ly_n   = lsy_q ? ly_q - 11'sd1 : ly_q + 11'sd1;
      lerr_n = lerr_n + ldx_q;
    end
    line_at_end = lxmaj_q ? (lx_q == 11'($signed({3'b0, xe_q})))
                          : (ly_q == 11'($signed({3'b0, ye_q})));
  end

  // circle next step
  logic signed [10:0] cu_n, cv_n, cd_n, cd_m;
  always_comb begin
    cv_n = cv_q;
    cd_m = cd_q;
    if (cd_q > -cv_q) begin
      cv_n = cv_q - 11'sd1;
      cd_m = cd_q + 11'sd1 - (cv_n <<< 1);
    end
    cu_n = cu_q;
    cd_n = cd_m;
    if (cd_m <= cu_q) begin
      cu_n = cu_q + 11'sd1;
      cd_n = cd_m + 11'sd1 + (cu_n <<< 1);
    end
  end

  logic scr_ok;
  assign scr_ok = ({1'b0, scroll_top_i} <= scroll_end_i) &&
                  (scroll_end_i <= 9'(TextLines)) && (scroll_end_i >= 9'd1);

  assign sts_o.line_last     = (lphase_q == 2'd2);
  assign sts_o.circ_last     = czero_q ||
                               (cpt_q[1:0] == 2'd3 && cv_n == 11'sd0);
  assign sts_o.row_last      = (row_q + 9'd1 == row_end_q);
  assign sts_o.scr_ok        = scr_ok;
  assign sts_o.scr_copy_last = (row_q >= row_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      pixel_value_o <= 1'b0;
    end else begin
      if (we) begin
        vld_q[addr] <= 1'b1;
      end
      if (ctl_i.load) begin
        pixel_value_o <= 1'b0;
      end else if (ctl_i.pix_wr && kind_q == REQ_TEST) begin
        pixel_value_o <= pix_on & rrow_q[px_q[ColAw-1:0]];
      end
    end
  end

  // payload and stepper registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.pix_rd) begin
      raddr_q <= py_q[RowAw-1:0];
    end else if (ctl_i.scr_rd) begin
      raddr_q <= scr_src_q;
    end
    if (ctl_i.load) begin
      kind_q   <= req_e'(req_type_i);
      xs_q     <= x_start_i;
      ys_q     <= y_start_i;
      xe_q     <= x_end_i;
      ye_q     <= y_end_i;
      px_q     <= 11'($signed({3'b0, x_start_i}));
      py_q     <= 11'($signed({3'b0, y_start_i}));
      pix_op_q <= (req_type_i == REQ_CLR) ? 2'd1 :
                  (req_type_i == REQ_INV) ? 2'd2 : 2'd0;
      lphase_q <= 2'd0;
      cpt_q    <= '0;
      cstep_q  <= 1'b0;
      czero_q  <= (radius_i == 8'd0);
      cu_q     <= '0;
      cv_q     <= 11'($signed({3'b0, radius_i}));
      cd_q     <= 11'sd2 - 11'($signed({2'b0, radius_i, 1'b0}));
      lx_q     <= 11'($signed({3'b0, x_start_i}));
      ly_q     <= 11'($signed({3'b0, y_start_i}));
      ldx_q    <= (x_end_i > x_start_i) ? 11'($signed({2'b0, x_end_i - x_start_i, 1'b0}))
                                        : 11'($signed({2'b0, x_start_i - x_end_i, 1'b0}));
      ldy_q    <= (y_end_i > y_start_i) ? 11'($signed({2'b0, y_end_i - y_start_i, 1'b0}))
                                        : 11'($signed({2'b0, y_start_i - y_end_i, 1'b0}));
      lsx_q    <= (x_end_i < x_start_i);
      lsy_q    <= (y_end_i < y_start_i);
    end
    if (ctl_i.line_init) begin
      lxmaj_q  <= (ldx_q > ldy_q);
      lerr_q   <= (ldx_q > ldy_q) ? ldy_q - (ldx_q >>> 1) : ldx_q - (ldy_q >>> 1);
      lphase_q <= 2'd0;
      px_q     <= nx;
      py_q     <= ny;
    end
    if (ctl_i.line_step) begin
      // phase 0: start point done, step or end; phase 1: step or end
      if (lphase_q == 2'd0 || lphase_q == 2'd1) begin
        if (line_at_end) begin
          lphase_q <= 2'd2;
          px_q     <= 11'($signed({3'b0, xe_q}));
          py_q     <= 11'($signed({3'b0, ye_q}));
        end else begin
          lphase_q <= 2'd1;
          lx_q     <= lx_n;
          ly_q     <= ly_n;
          lerr_q   <= lerr_n;
          px_q     <= lx_n;
          py_q     <= ly_n;
        end
      end
    end
    if (ctl_i.circ_init) begin
      px_q     <= nx;
      py_q     <= ny;
      pix_op_q <= 2'd0;
    end
    if (ctl_i.circ_step) begin
      if (!cstep_q && cpt_q[1:0] != 2'd3) begin
        cpt_q <= cpt_q + 3'd1;
      end else if (cstep_q && cpt_q[1:0] != 2'd3) begin
        cpt_q <= cpt_q + 3'd1;
      end else begin
        cstep_q <= 1'b1;
        cpt_q   <= '0;
        cu_q    <= cu_n;
        cv_q    <= cv_n;
        cd_q    <= cd_n;
      end
    end
    if (ctl_i.circ_step) begin
      px_q <= 11'($signed({3'b0, xs_q}));
      py_q <= 11'($signed({3'b0, ys_q}));
      // next point computed from updated registers next cycle via circ_init
    end
    if (ctl_i.row_init) begin
      if (kind_q == REQ_CLRTXT) begin
        row_q     <= {ys_q[5:0], 3'b000};
        row_end_q <= {ys_q[5:0], 3'b000} + 9'd8;
      end else if (kind_q == REQ_CLRALL) begin
        row_q     <= '0;
        row_end_q <= 9'(ScreenH);
      end else begin
        // scroll: blank the last text line of the window
        row_q     <= {scroll_end_i[5:0] - 6'd1, 3'b000};
        row_end_q <= {scroll_end_i[5:0], 3'b000};
      end
    end
    if (ctl_i.scr_init) begin
      row_q     <= {scroll_top_i[5:0], 3'b000};
      row_end_q <= {scroll_end_i[5:0] - 6'd1, 3'b000};
      scr_src_q <= RowAw'({scroll_top_i[5:0], 3'b000} + 9'd8);
    end
    if (ctl_i.scr_wr) begin
      row_q     <= row_q + 9'd1;
      scr_src_q <= RowAw'(row_q + 9'd9);
    end
    if (ctl_i.row_clr) begin
      row_q <= row_q + 9'd1;
    end
  end

`ifndef ASSERT_OFF
  a_one_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.pix_wr, ctl_i.row_clr, ctl_i.scr_wr}))
    else $error("two writers on bitmap port");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scr_wr |-> (row_q < 9'(ScreenH)))
    else $error("scroll copy beyond screen");
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |=> !pixel_value_o)
    else $error("result not cleared on new command");
`endif

endmodule

@@ sv/lbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbd_ctrl
// Command sequencer: pixel read-modify-write, line and circle walks, row sweeps.
// ----------------------------------------------------------------------------
module lbd_ctrl import lbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [3:0] req_type_i,
  input  logic [7:0] y_start_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;
  req_e   kind_q;
  logic   sub_q, sub_d;  // 0 before the init step of a walk or sweep, 1 after it

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sub_q   <= 1'b0;
      kind_q  <= REQ_SET;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      if (start_i && state_q == ST_IDLE) begin
        kind_q <= req_e'(req_type_i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          sub_d      = 1'b0;
          unique case (req_type_i)
            REQ_SET, REQ_CLR, REQ_INV, REQ_TEST: state_d = ST_PIX_RD;
            REQ_LINE:   state_d = ST_LINE;
            REQ_CIRCLE: state_d = ST_CIRC;
            REQ_CLRTXT: state_d = (y_start_i < 8'(TextLines)) ? ST_ROWCLR : ST_DONE;
            REQ_CLRALL: state_d = ST_ROWCLR;
            REQ_SCROLL: state_d = ST_SCR_RD;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_PIX_RD: begin
        ctl_o.pix_rd = 1'b1;
        state_d      = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ctl_o.pix_wr = (kind_q != REQ_TEST);
        if (kind_q == REQ_TEST) begin
          ctl_o.pix_wr = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_LINE: begin
        // sub 0: first entry init; then read, write alternating
        if (!sub_q) begin
          ctl_o.line_init = 1'b1;
          sub_d           = 1'b1;
          state_d         = ST_PIX_RD;
        end
      end
      ST_CIRC: begin
        if (!sub_q) begin
          ctl_o.circ_init = 1'b1;
          sub_d           = 1'b1;
          state_d         = ST_PIX_RD;
        end
      end
      ST_ROWCLR: begin
        if (!sub_q) begin
          ctl_o.row_init = 1'b1;
          sub_d          = 1'b1;
        end else begin
          ctl_o.row_clr = 1'b1;
          if (sts_i.row_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCR_RD: begin
        if (!sub_q) begin
          if (!sts_i.scr_ok) begin
            state_d = ST_DONE;
          end else begin
            ctl_o.scr_init = 1'b1;
            sub_d          = 1'b1;
          end
        end else begin
          if (sts_i.scr_copy_last) begin
            state_d = ST_ROWCLR;
            sub_d   = 1'b0;
          end else begin
            ctl_o.scr_rd = 1'b1;
            state_d      = ST_SCR_WR;
          end
        end
      end
      ST_SCR_WR: begin
        ctl_o.scr_wr = 1'b1;
        state_d      = ST_SCR_RD;
      end
      ST_DONE: begin
        ctl_o.done = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // point loops: after writing a point go back to the walker
    if (state_q == ST_PIX_WR && kind_q == REQ_LINE) begin
      if (sts_i.line_last) begin
        state_d = ST_DONE;
      end else begin
        ctl_o.line_step = 1'b1;
        state_d         = ST_PIX_RD;
      end
    end
    if (state_q == ST_PIX_WR && kind_q == REQ_CIRCLE) begin
      if (sts_i.circ_last) begin
        state_d = ST_DONE;
      end else begin
        ctl_o.circ_step = 1'b1;
        state_d         = ST_CIRC;
        sub_d           = 1'b0;
      end
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = ctl_o.done;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command not taken");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("done without return to idle");
  a_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.pix_rd |=> (state_q == ST_PIX_WR))
    else $error("pixel read without write phase");
`endif

endmodule

@@ sv/lcd_bitmap_draw_engine.sv @@
// ----------------------------------------------------------------------------
// lcd_bitmap_draw_engine
// 120x32 one-bit bitmap with pixel, line, circle, clear and scroll commands.
//
//   channel  ports                                    handshake
//   command  req_type_i x_start_i y_start_i ...       start, taken when !busy
//   result   pixel_value_o                            done_o, one cycle
//   config   cfg_we_i cfg_idx_i cfg_data_i            write on cfg_we_i
//
// A pixel command reads its row and, but for a test, writes it back; a line and
// a circle do so for each plotted point, all through the single bitmap row port;
// clear text line and clear all write zero rows, and scroll copies rows up and
// then blanks the last text line of the window (nothing when it is invalid).
// Rows read as blank until first written, so reset needs no clearing pass.
// The result cannot be stalled; it is valid with done_o and holds until the next command.
// ----------------------------------------------------------------------------
module lcd_bitmap_draw_engine import lbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] req_type_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [7:0] radius_i,
  output logic       done_o,
  output logic       pixel_value_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [8:0] cfg_data_i
);

  ctl_t       ctl;
  sts_t       sts;
  logic [7:0] scroll_top_q;
  logic [8:0] scroll_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_top_q <= 8'd0;
      scroll_end_q <= 9'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScrollTop: scroll_top_q <= cfg_data_i[7:0];
        CfgScrollEnd: scroll_end_q <= cfg_data_i;
        default:      scroll_top_q <= scroll_top_q;
      endcase
    end
  end

  lbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_type_i(req_type_i),
    .y_start_i (y_start_i),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy_o    (busy),
    .done_o    (done_o)
  );

  lbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .radius_i     (radius_i),
    .scroll_top_i (scroll_top_q),
    .scroll_end_i (scroll_end_q),
    .pixel_value_o(pixel_value_o)
  );

endmodule
